FILE: sv/color_bar_pattern_pixel_generator_unit_macros.svh
// assertion macros for the color bar pattern generator checker
`ifndef COLOR_BAR_PATTERN_PIXEL_GENERATOR_UNIT_MACROS_SVH
`define COLOR_BAR_PATTERN_PIXEL_GENERATOR_UNIT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define CBP_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, active during reset too
`define CBP_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/cbp_pkg.sv
// shared types and constants of the color bar pattern generator
package cbp_pkg;

    localparam int PIX_W     = 11;
    localparam int RES_W     = 12;
    localparam int GRID_W    = 8;
    localparam int COLOR_W   = 32;
    localparam int STEP_W    = 8;
    localparam int BPP_W     = 6;
    localparam int LAYOUT_W  = 30;
    localparam int ADDR_W    = 24;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 1;

    localparam int FIFO_DEPTH = 16;

    localparam logic [RES_W-1:0]    X_RES_RST  = 12'd1024;
    localparam logic [RES_W-1:0]    Y_RES_RST  = 12'd768;
    localparam logic [GRID_W-1:0]   GRID_RST   = 8'd1;
    localparam logic [COLOR_W-1:0]  FIRST_RST  = 32'd0;
    localparam logic [STEP_W-1:0]   STEP_RST   = 8'd0;
    localparam logic                INDEX_RST  = 1'b1;
    localparam logic [BPP_W-1:0]    BPP_RST    = 6'd8;
    localparam logic [LAYOUT_W-1:0] LAYOUT_RST = 30'd167974059;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_RES  = 4'd0,
        REG_Y_RES  = 4'd1,
        REG_GRID   = 4'd2,
        REG_FIRST  = 4'd3,
        REG_STEP   = 4'd4,
        REG_INDEX  = 4'd5,
        REG_BPP    = 4'd6,
        REG_LAYOUT = 4'd7
    } cbp_reg_t;

    typedef struct packed {
        logic [RES_W-1:0]    x_lim;
        logic [RES_W-1:0]    y_lim;
        logic [GRID_W-1:0]   grid;
        logic [COLOR_W-1:0]  first;
        logic [STEP_W-1:0]   step;
        logic                indexed;
        logic [BPP_W-1:0]    bpp;
        logic [LAYOUT_W-1:0] layout;
        logic [RES_W-1:0]    rect_w;
        logic [RES_W-1:0]    rect_h;
        logic                ready;
    } cbp_cfg_t;

    typedef struct packed {
        logic              drawn;
        logic [GRID_W-1:0] row;
        logic [GRID_W-1:0] col;
        logic [PIX_W-1:0]  x;
        logic [PIX_W-1:0]  y;
    } cbp_item_t;

endpackage

FILE: sv/cbp_cfg.sv
// configuration registers and bit-serial rectangle size divider
module cbp_cfg
    import cbp_pkg::*;
#(
    parameter int MAX_RESOLUTION = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cbp_cfg_t              cfg_bus
);

    localparam int CNT_W = $clog2(RES_W + 1);

    logic [RES_W-1:0]    x_res_reg;
    logic [RES_W-1:0]    y_res_reg;
    logic [GRID_W-1:0]   grid_reg;
    logic [COLOR_W-1:0]  first_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                index_reg;
    logic [BPP_W-1:0]    bpp_reg;
    logic [LAYOUT_W-1:0] layout_reg;

    logic                pend_reg, pend_next;
    logic                busy_reg, busy_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [RES_W-1:0]    dvdw_reg, dvdw_next;
    logic [RES_W-1:0]    dvdh_reg, dvdh_next;
    logic [GRID_W-1:0]   remw_reg, remw_next;
    logic [GRID_W-1:0]   remh_reg, remh_next;

    logic                cfg_wr;
    logic [RES_W-1:0]    x_lim;
    logic [RES_W-1:0]    y_lim;
    logic [GRID_W:0]     trial_w;
    logic [GRID_W:0]     trial_h;
    logic                ge_w;
    logic                ge_h;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    assign x_lim = ({1'b0, x_res_reg} > (RES_W + 1)'(MAX_RESOLUTION)) ?
                   RES_W'(MAX_RESOLUTION) : x_res_reg;
    assign y_lim = ({1'b0, y_res_reg} > (RES_W + 1)'(MAX_RESOLUTION)) ?
                   RES_W'(MAX_RESOLUTION) : y_res_reg;

    // restoring division step, one quotient bit per cycle for width and height
    assign trial_w = {remw_reg, dvdw_reg[RES_W-1]};
    assign trial_h = {remh_reg, dvdh_reg[RES_W-1]};
    assign ge_w    = trial_w >= {1'b0, grid_reg};
    assign ge_h    = trial_h >= {1'b0, grid_reg};

    always_comb begin
        pend_next = pend_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvdw_next = dvdw_reg;
        dvdh_next = dvdh_reg;
        remw_next = remw_reg;
        remh_next = remh_reg;
        if (pend_reg) begin
            pend_next = 1'b0;
            busy_next = 1'b1;
            cnt_next  = CNT_W'(RES_W);
            dvdw_next = x_lim;
            dvdh_next = y_lim;
            remw_next = '0;
            remh_next = '0;
        end else if (busy_reg) begin
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = cnt_reg != CNT_W'(1);
            dvdw_next = {dvdw_reg[RES_W-2:0], ge_w};
            dvdh_next = {dvdh_reg[RES_W-2:0], ge_h};
            remw_next = ge_w ? GRID_W'(trial_w - {1'b0, grid_reg}) : trial_w[GRID_W-1:0];
            remh_next = ge_h ? GRID_W'(trial_h - {1'b0, grid_reg}) : trial_h[GRID_W-1:0];
        end
        if (cfg_wr) begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_res_reg  <= X_RES_RST;
            y_res_reg  <= Y_RES_RST;
            grid_reg   <= GRID_RST;
            first_reg  <= FIRST_RST;
            step_reg   <= STEP_RST;
            index_reg  <= INDEX_RST;
            bpp_reg    <= BPP_RST;
            layout_reg <= LAYOUT_RST;
            pend_reg   <= 1'b1;
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            pend_reg <= pend_next;
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            if (cfg_wr) begin
                case (cfg_index)
                    REG_X_RES:  x_res_reg  <= cfg_data[RES_W-1:0];
                    REG_Y_RES:  y_res_reg  <= cfg_data[RES_W-1:0];
                    REG_GRID:   grid_reg   <= cfg_data[GRID_W-1:0];
                    REG_FIRST:  first_reg  <= cfg_data[COLOR_W-1:0];
                    REG_STEP:   step_reg   <= cfg_data[STEP_W-1:0];
                    REG_INDEX:  index_reg  <= cfg_data[0];
                    REG_BPP:    bpp_reg    <= cfg_data[BPP_W-1:0];
                    REG_LAYOUT: layout_reg <= cfg_data[LAYOUT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        dvdw_reg <= dvdw_next;
        dvdh_reg <= dvdh_next;
        remw_reg <= remw_next;
        remh_reg <= remh_next;
    end

    always_comb begin
        cfg_bus.x_lim   = x_lim;
        cfg_bus.y_lim   = y_lim;
        cfg_bus.grid    = grid_reg;
        cfg_bus.first   = first_reg;
        cfg_bus.step    = step_reg;
        cfg_bus.indexed = index_reg;
        cfg_bus.bpp     = bpp_reg;
        cfg_bus.layout  = layout_reg;
        cfg_bus.rect_w  = dvdw_reg;
        cfg_bus.rect_h  = dvdh_reg;
        cfg_bus.ready   = !pend_reg && !busy_reg;
    end

endmodule

FILE: sv/cbp_front.sv
// input side: grid column and row by pipelined division, drawn classification
module cbp_front
    import cbp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cbp_cfg_t             cfg_bus,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 pop,
    output logic                 push,
    output cbp_item_t            push_item
);

    localparam int NSTG   = PIX_W;
    localparam int RESV_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic             inr;
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic [RES_W-1:0] rx;
        logic [RES_W-1:0] ry;
        logic [PIX_W-1:0] qx;
        logic [PIX_W-1:0] qy;
    } stage_t;

    function automatic logic [RES_W:0] div_step(
        input logic [RES_W-1:0] rem,
        input logic             nb,
        input logic [RES_W-1:0] dv
    );
        logic [RES_W:0] trial;
        trial = {rem, nb};
        if (trial >= {1'b0, dv}) begin
            return {1'b1, RES_W'(trial - {1'b0, dv})};
        end
        return {1'b0, trial[RES_W-1:0]};
    endfunction

    stage_t             stg_reg  [NSTG];
    stage_t             stg_next [NSTG];
    logic [NSTG-1:0]    vld_reg;
    logic [RESV_W-1:0]  resv_reg;

    logic [PIX_W-1:0]   in_x;
    logic [PIX_W-1:0]   in_y;
    logic               accept;
    logic [RES_W:0]     sx0;
    logic [RES_W:0]     sy0;
    stage_t             last;

    assign in_x = s_axis_tdata[PIX_W-1:0];
    assign in_y = s_axis_tdata[2*PIX_W-1:PIX_W];

    // queue slots are reserved at acceptance so the division pipeline never stalls
    assign s_axis_tready = cfg_bus.ready && (resv_reg < RESV_W'(FIFO_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign sx0 = div_step('0, in_x[PIX_W-1], cfg_bus.rect_w);
    assign sy0 = div_step('0, in_y[PIX_W-1], cfg_bus.rect_h);

    always_comb begin
        stg_next[0].inr = ({1'b0, in_x} < cfg_bus.x_lim) && ({1'b0, in_y} < cfg_bus.y_lim);
        stg_next[0].x   = in_x;
        stg_next[0].y   = in_y;
        stg_next[0].rx  = sx0[RES_W-1:0];
        stg_next[0].ry  = sy0[RES_W-1:0];
        stg_next[0].qx  = PIX_W'(sx0[RES_W]);
        stg_next[0].qy  = PIX_W'(sy0[RES_W]);
    end

    for (genvar k = 1; k < NSTG; k++) begin : g_stage
        logic [RES_W:0] sx;
        logic [RES_W:0] sy;
        assign sx = div_step(stg_reg[k-1].rx, stg_reg[k-1].x[PIX_W-1-k], cfg_bus.rect_w);
        assign sy = div_step(stg_reg[k-1].ry, stg_reg[k-1].y[PIX_W-1-k], cfg_bus.rect_h);
        always_comb begin
            stg_next[k]    = stg_reg[k-1];
            stg_next[k].rx = sx[RES_W-1:0];
            stg_next[k].ry = sy[RES_W-1:0];
            stg_next[k].qx = {stg_reg[k-1].qx[PIX_W-2:0], sx[RES_W]};
            stg_next[k].qy = {stg_reg[k-1].qy[PIX_W-2:0], sy[RES_W]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            resv_reg <= '0;
        end else begin
            vld_reg  <= {vld_reg[NSTG-2:0], accept};
            resv_reg <= resv_reg + RESV_W'(accept) - RESV_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NSTG; k++) begin
            stg_reg[k] <= stg_next[k];
        end
    end

    assign last = stg_reg[NSTG-1];
    assign push = vld_reg[NSTG-1];

    always_comb begin
        push_item.drawn = last.inr && (cfg_bus.grid != '0) &&
                          (cfg_bus.rect_w != '0) && (cfg_bus.rect_h != '0) &&
                          (last.qx < PIX_W'(cfg_bus.grid)) && (last.qy < PIX_W'(cfg_bus.grid));
        push_item.row   = last.qy[GRID_W-1:0];
        push_item.col   = last.qx[GRID_W-1:0];
        push_item.x     = last.x;
        push_item.y     = last.y;
    end

endmodule

FILE: sv/cbp_fifo.sv
// short queue between the classifying front and the color back end
module cbp_fifo
    import cbp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cbp_item_t push_item,
    input  logic      pop,
    output logic      not_empty,
    output cbp_item_t pop_item
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cbp_item_t        mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign not_empty = count_reg != '0;
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: sv/cbp_back.sv
// back end: color and byte address pipeline with the output register
module cbp_back
    import cbp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cbp_cfg_t             cfg_bus,
    input  logic                 item_valid,
    input  cbp_item_t            item,
    output logic                 pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic [M_TUSER_W-1:0] m_axis_tuser
);

    localparam int PROD_W = GRID_W + STEP_W;
    localparam int LIN_W  = PIX_W + RES_W;

    typedef struct packed {
        logic              drawn;
        logic [PROD_W-1:0] row_n;
        logic [GRID_W-1:0] col;
        logic [PROD_W-1:0] prod_r;
        logic [PROD_W-1:0] prod_g;
        logic [LIN_W-1:0]  ylin;
        logic [PIX_W-1:0]  x;
    } b1_t;

    typedef struct packed {
        logic              drawn;
        logic [PROD_W-1:0] idx;
        logic [ADDR_W-1:0] lin;
        logic [PROD_W-1:0] prod_r;
        logic [PROD_W-1:0] prod_g;
        logic [PROD_W:0]   prod_b;
    } b2_t;

    typedef struct packed {
        logic               drawn;
        logic [ADDR_W-1:0]  idxs;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] rgb;
    } b3_t;

    function automatic logic [COLOR_W-1:0] ones(input logic [BPP_W-1:0] n);
        logic [COLOR_W:0] t;
        t = (COLOR_W + 1)'(1) << n;
        t = t - (COLOR_W + 1)'(1);
        if (n >= BPP_W'(COLOR_W)) begin
            return '1;
        end
        return t[COLOR_W-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] chan(
        input logic [COLOR_W-1:0] first,
        input logic [4:0]         pos,
        input logic [4:0]         size,
        input logic [PROD_W:0]    prod
    );
        logic [COLOR_W-1:0] m;
        logic [COLOR_W-1:0] base;
        m    = ones(BPP_W'(size));
        base = (first >> pos) & m;
        return ((base + COLOR_W'(prod)) & m) << pos;
    endfunction

    logic [3:0]         vld_reg;
    b1_t                b1_reg, b1_next;
    b2_t                b2_reg, b2_next;
    b3_t                b3_reg, b3_next;
    logic               drawn_reg;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;

    logic               adv;
    logic [3:0]         bytes;

    assign adv = !vld_reg[3] || m_axis_tready;
    assign pop = item_valid && adv;

    assign bytes = 4'(({1'b0, cfg_bus.bpp} + 7'd7) >> 3);

    always_comb begin
        b1_next.drawn  = item.drawn;
        b1_next.row_n  = PROD_W'(item.row) * PROD_W'(cfg_bus.grid);
        b1_next.col    = item.col;
        b1_next.prod_r = PROD_W'(item.col) * PROD_W'(cfg_bus.step);
        b1_next.prod_g = PROD_W'(item.row) * PROD_W'(cfg_bus.step);
        b1_next.ylin   = LIN_W'(item.y) * LIN_W'(cfg_bus.x_lim);
        b1_next.x      = item.x;

        b2_next.drawn  = b1_reg.drawn;
        b2_next.idx    = b1_reg.row_n + PROD_W'(b1_reg.col);
        b2_next.lin    = ADDR_W'(b1_reg.ylin) + ADDR_W'(b1_reg.x);
        b2_next.prod_r = b1_reg.prod_r;
        b2_next.prod_g = b1_reg.prod_g;
        b2_next.prod_b = (PROD_W + 1)'(b1_reg.prod_r) + (PROD_W + 1)'(b1_reg.prod_g);

        b3_next.drawn = b2_reg.drawn;
        b3_next.idxs  = ADDR_W'(b2_reg.idx) * ADDR_W'(cfg_bus.step);
        b3_next.addr  = ADDR_W'(ADDR_W'(bytes) * b2_reg.lin);
        b3_next.rgb   = chan(cfg_bus.first, cfg_bus.layout[4:0], cfg_bus.layout[9:5],
                             (PROD_W + 1)'(b2_reg.prod_r))
                      | chan(cfg_bus.first, cfg_bus.layout[14:10], cfg_bus.layout[19:15],
                             (PROD_W + 1)'(b2_reg.prod_g))
                      | chan(cfg_bus.first, cfg_bus.layout[24:20], cfg_bus.layout[29:25],
                             b2_reg.prod_b);

        color_next = '0;
        addr_next  = '0;
        if (b3_reg.drawn) begin
            color_next = cfg_bus.indexed ? cfg_bus.first + COLOR_W'(b3_reg.idxs) : b3_reg.rgb;
            color_next = color_next & ones(cfg_bus.bpp);
            addr_next  = b3_reg.addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[2:0], pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b1_reg    <= b1_next;
            b2_reg    <= b2_next;
            b3_reg    <= b3_next;
            drawn_reg <= b3_reg.drawn;
            color_reg <= color_next;
            addr_reg  <= addr_next;
        end
    end

    assign m_axis_tvalid = vld_reg[3];
    assign m_axis_tdata  = {addr_reg, color_reg};
    assign m_axis_tuser  = drawn_reg;

endmodule

FILE: sv/color_bar_pattern_pixel_generator_unit.sv
// top level of the rectangle grid color bar pattern generator
// Takes one pixel coordinate per clock and returns one result per clock in
// steady state while neither side stalls; once its coordinate is accepted, a
// result passes through the 11-stage column/row division pipeline, the queue
// and four color and address stages. The input stays stalled after reset and
// after every configuration write while a bit-serial divider works out the
// rectangle width and height. Input slots are reserved in a 16-entry queue,
// so a stalled output holds off new coordinates only once that queue is full.
module color_bar_pattern_pixel_generator_unit
    import cbp_pkg::*;
#(
    parameter int MAX_RESOLUTION = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // pixel_x, pixel_y, zero pad
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // pixel_color, pixel_address
    output logic [M_TUSER_W-1:0]  m_axis_tuser   // pixel_drawn
);

    cbp_cfg_t  cfg_bus;
    logic      push;
    logic      pop;
    logic      fifo_valid;
    cbp_item_t push_item;
    cbp_item_t pop_item;

    cbp_cfg #(
        .MAX_RESOLUTION(MAX_RESOLUTION)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_bus   (cfg_bus)
    );

    cbp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_bus       (cfg_bus),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .pop           (pop),
        .push          (push),
        .push_item     (push_item)
    );

    cbp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .not_empty (fifo_valid),
        .pop_item  (pop_item)
    );

    cbp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_bus       (cfg_bus),
        .item_valid    (fifo_valid),
        .item          (pop_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: sv/cbp_checker.sv
// port-level assertions for the color bar pattern generator, bound to the top
`include "color_bar_pattern_pixel_generator_unit_macros.svh"

module cbp_checker
    import cbp_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata,
    input logic [M_TUSER_W-1:0]  m_axis_tuser
);

    logic                           out_stall;
    logic                           out_blank;
    logic                           cfg_wr;
    logic [M_TDATA_W+M_TUSER_W:0]   out_bus;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_blank = m_axis_tvalid && !m_axis_tuser[0];
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign out_bus   = {m_axis_tvalid, m_axis_tuser, m_axis_tdata};

    // a stalled result transaction holds its payload
    `CBP_ASSERT_RST(a_out_hold, aclk, aresetn, out_stall |=> $stable(out_bus), "result moved")
    // pixels outside the grid carry zero color and address
    `CBP_ASSERT_RST(a_blank_zero, aclk, aresetn, out_blank |-> m_axis_tdata == '0, "blank not zero")
    // a register write holds off input while the rectangle size is recomputed
    `CBP_ASSERT_RST(a_cfg_stall, aclk, aresetn, cfg_wr |=> !s_axis_tready, "input open after write")
    // reset leaves both channels quiet
    `CBP_ASSERT(a_reset_quiet, aclk, !aresetn |=> !m_axis_tvalid && !s_axis_tready, "busy after reset")

endmodule

bind color_bar_pattern_pixel_generator_unit cbp_checker u_cbp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: test/color_bar_pattern_pixel_generator_unit_tb.sv
// self-checking testbench for the rectangle grid color bar pattern generator
`timescale 1ns / 100ps

module color_bar_pattern_pixel_generator_unit_tb;
    import cbp_pkg::*;

    localparam int unsigned MAX_RES = 2048;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [PIX_W-1:0] y;
        logic [PIX_W-1:0] x;
    } pixel_coord_t;

    typedef struct packed {
        logic               drawn;
        logic [COLOR_W-1:0] color;
        logic [ADDR_W-1:0]  addr;
    } pixel_result_t;

    typedef struct packed {
        cbp_reg_t              idx;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_X_RES;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;

    logic [RES_W-1:0]    cur_xres    = X_RES_RST;
    logic [RES_W-1:0]    cur_yres    = Y_RES_RST;
    logic [GRID_W-1:0]   cur_grid    = GRID_RST;
    logic [COLOR_W-1:0]  cur_first   = FIRST_RST;
    logic [STEP_W-1:0]   cur_step    = STEP_RST;
    logic                cur_indexed = INDEX_RST;
    logic [BPP_W-1:0]    cur_bpp     = BPP_RST;
    logic [LAYOUT_W-1:0] cur_layout  = LAYOUT_RST;

    pixel_coord_t  pixel_queue[$];
    pixel_result_t expected_pixels[$];
    reg_write_t    reg_writes[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned sink_hold_cycles = 0;
    int unsigned src_gap = 0;
    int unsigned sink_gap = 0;

    color_bar_pattern_pixel_generator_unit #(
        .MAX_RESOLUTION(MAX_RES)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [31:0] width_mask(int unsigned bits);
        if (bits >= 32)
            return 32'hFFFF_FFFF;
        return (32'd1 << bits) - 32'd1;
    endfunction

    function automatic logic [31:0] channel_color(int k, int unsigned mult);
        logic [4:0]  pos;
        logic [31:0] m;
        logic [31:0] base;
        pos  = cur_layout[10*k +: 5];
        m    = width_mask(cur_layout[10*k+5 +: 5]);
        base = (cur_first >> pos) & m;
        return ((base + mult * cur_step) & m) << pos;
    endfunction

    function automatic int unsigned clamp_res(logic [RES_W-1:0] res);
        return (res > MAX_RES) ? MAX_RES : res;
    endfunction

    function automatic pixel_result_t render_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        int unsigned   xr, yr, n, w, h, col, row, nbytes;
        logic [31:0]   color;
        pixel_result_t r;
        r  = '0;
        xr = clamp_res(cur_xres);
        yr = clamp_res(cur_yres);
        n  = cur_grid;
        if (n != 0 && px < xr && py < yr) begin
            w = xr / n;
            h = yr / n;
            if (w != 0 && h != 0) begin
                col = px / w;
                row = py / h;
                r.drawn = (row < n) && (col < n);
            end
        end
        if (r.drawn) begin
            if (cur_indexed)
                color = cur_first + (row * n + col) * cur_step;
            else
                color = channel_color(0, col) | channel_color(1, row)
                      | channel_color(2, row + col);
            r.color = color & width_mask(cur_bpp);
            nbytes  = (cur_bpp + 7) / 8;
            r.addr  = ADDR_W'(nbytes * (px + py * xr));
        end
        return r;
    endfunction

    function automatic int unsigned draw_gap(int unsigned idle_pct);
        if ($urandom_range(99) >= idle_pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(60, 20);
        return $urandom_range(3, 1);
    endfunction

    task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // configuration writes
    always @(posedge aclk) begin : reg_drive
        reg_write_t w;
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cbp_reg_t'(cfg_index))
                    REG_X_RES:  cur_xres    <= cfg_data[RES_W-1:0];
                    REG_Y_RES:  cur_yres    <= cfg_data[RES_W-1:0];
                    REG_GRID:   cur_grid    <= cfg_data[GRID_W-1:0];
                    REG_FIRST:  cur_first   <= cfg_data[COLOR_W-1:0];
                    REG_STEP:   cur_step    <= cfg_data[STEP_W-1:0];
                    REG_INDEX:  cur_indexed <= cfg_data[0];
                    REG_BPP:    cur_bpp     <= cfg_data[BPP_W-1:0];
                    REG_LAYOUT: cur_layout  <= cfg_data[LAYOUT_W-1:0];
                    default: ;
                endcase
            end
            if (!cfg_valid || cfg_ready) begin
                if (reg_writes.size() != 0) begin
                    w = reg_writes.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= w.idx;
                    cfg_data  <= w.data;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // coordinate driver, predicts each accepted transaction
    always @(posedge aclk) begin : pixel_drive
        pixel_coord_t c;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_pixels.push_back(render_pixel(s_axis_tdata[PIX_W-1:0],
                                                       s_axis_tdata[2*PIX_W-1:PIX_W]));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pixel_queue.size() != 0) begin
                    c = pixel_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(S_TDATA_W-2*PIX_W){1'b0}}, c.y, c.x};
                    src_gap = draw_gap(src_idle_pct);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and sink stalls
    always @(posedge aclk) begin : result_check
        pixel_result_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual drawn %b color %h addr %h",
                             $time, m_axis_tuser[0], m_axis_tdata[COLOR_W-1:0],
                             m_axis_tdata[COLOR_W +: ADDR_W]);
                    mismatch_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    compare_field("pixel_drawn", 32'(want.drawn), 32'(m_axis_tuser[0]));
                    compare_field("pixel_color", want.color, m_axis_tdata[COLOR_W-1:0]);
                    compare_field("pixel_address", 32'(want.addr),
                                  32'(m_axis_tdata[COLOR_W +: ADDR_W]));
                end
            end
            if (sink_hold_cycles > 0) begin
                sink_hold_cycles--;
                m_axis_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                sink_gap = draw_gap(sink_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d pixel results outstanding", $time, expected_pixels.size());
            $display("** color_bar_pattern_pixel_generator_unit: FAILED **");
            $finish;
        end
    end

    task automatic set_reg(cbp_reg_t idx, logic [CFG_DATA_W-1:0] data);
        reg_writes.push_back('{idx: idx, data: data});
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pixel_queue.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
    endtask

    task automatic commit_regs();
        do @(negedge aclk);
        while (reg_writes.size() != 0 || cfg_valid);
    endtask

    task automatic push_pixel(int unsigned px, int unsigned py);
        pixel_queue.push_back('{x: PIX_W'(px), y: PIX_W'(py)});
    endtask

    function automatic logic [RES_W-1:0] pick_res();
        case ($urandom_range(9))
            0: return '0;
            1: return RES_W'($urandom_range(4095, MAX_RES + 1));
            2: return RES_W'(MAX_RES);
            default: return RES_W'($urandom_range(MAX_RES, 1));
        endcase
    endfunction

    task automatic random_setup();
        int unsigned r;
        set_reg(REG_X_RES, pick_res());
        set_reg(REG_Y_RES, pick_res());
        r = $urandom_range(9);
        set_reg(REG_GRID, (r == 0) ? 0 : (r == 1) ? 255 :
                          (r == 2) ? $urandom_range(255) : $urandom_range(16, 1));
        set_reg(REG_FIRST, $urandom);
        set_reg(REG_STEP, $urandom_range(255));
        set_reg(REG_INDEX, $urandom_range(1));
        set_reg(REG_BPP, ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(32, 1));
        set_reg(REG_LAYOUT, $urandom_range(1) ? ($urandom & 32'h3FFF_FFFF) : LAYOUT_RST);
        commit_regs();
    endtask

    task automatic random_pixels(int unsigned count);
        int unsigned xr, yr;
        xr = clamp_res(cur_xres);
        yr = clamp_res(cur_yres);
        repeat (count) begin
            if ($urandom_range(9) < 8 && xr != 0 && yr != 0)
                push_pixel($urandom_range(xr - 1), $urandom_range(yr - 1));
            else
                push_pixel($urandom & 11'h7FF, $urandom & 11'h7FF);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset defaults: corners and just off screen
        push_pixel(0, 0);
        push_pixel(1023, 767);
        push_pixel(1024, 5);
        push_pixel(5, 768);
        push_pixel(2047, 2047);
        wait_drained();

        // clamped resolution, widest grid, all-ones color, full depth
        set_reg(REG_X_RES, 4095);
        set_reg(REG_Y_RES, 2048);
        set_reg(REG_GRID, 255);
        set_reg(REG_FIRST, 32'hFFFF_FFFF);
        set_reg(REG_STEP, 255);
        set_reg(REG_INDEX, 1);
        set_reg(REG_BPP, 32);
        set_reg(REG_LAYOUT, 0);
        commit_regs();
        push_pixel(2047, 2047);
        push_pixel(2039, 2039);
        push_pixel(0, 0);
        wait_drained();

        // direct color with the default layout
        set_reg(REG_X_RES, 640);
        set_reg(REG_Y_RES, 480);
        set_reg(REG_GRID, 4);
        set_reg(REG_FIRST, 32'h0012_3456);
        set_reg(REG_STEP, 3);
        set_reg(REG_INDEX, 0);
        set_reg(REG_BPP, 24);
        set_reg(REG_LAYOUT, 32'(LAYOUT_RST));
        commit_regs();
        push_pixel(0, 0);
        push_pixel(639, 479);
        push_pixel(300, 200);
        wait_drained();

        // top channel position, empty channel, depth beyond 32
        set_reg(REG_GRID, 2);
        set_reg(REG_FIRST, $urandom);
        set_reg(REG_STEP, 255);
        set_reg(REG_BPP, 63);
        set_reg(REG_LAYOUT, 32'({5'd31, 5'd16, 5'd0, 5'd0, 5'd31, 5'd31}));
        commit_regs();
        push_pixel(639, 479);
        push_pixel(320, 0);
        wait_drained();

        // zero grid
        set_reg(REG_GRID, 0);
        commit_regs();
        push_pixel(0, 0);
        push_pixel(1, 1);
        wait_drained();

        // zero-width rectangles
        set_reg(REG_X_RES, 4);
        set_reg(REG_GRID, 5);
        commit_regs();
        push_pixel(0, 0);
        wait_drained();

        // single pixel screen, zero depth
        set_reg(REG_X_RES, 1);
        set_reg(REG_Y_RES, 1);
        set_reg(REG_GRID, 1);
        set_reg(REG_BPP, 0);
        commit_regs();
        push_pixel(0, 0);
        push_pixel(1, 0);
        wait_drained();

        for (int k = 0; k < 14; k++) begin
            random_setup();
            src_idle_pct  = (k % 4 == 0) ? 0 : $urandom_range(60);
            sink_idle_pct = (k % 4 == 0) ? 0 : $urandom_range(60);
            if (k == 6) begin
                // sink held off while the source streams
                src_idle_pct  = 0;
                sink_idle_pct = 0;
                sink_hold_cycles = 300;
                random_pixels(80);
            end else if (k == 9) begin
                random_pixels(30);
                wait_drained();
                random_pixels(30);
            end else begin
                random_pixels(60);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_pixels.size() != 0) begin
            $display("%0t: %0d pixel results never arrived", $time, expected_pixels.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("** color_bar_pattern_pixel_generator_unit: PASSED **");
        else
            $display("** color_bar_pattern_pixel_generator_unit: FAILED **");
        $finish;
    end

endmodule
